// File: rtl/device_discovery_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Device discovery table assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DEVICE_DISCOVERY_TABLE_UNIT_MACROS_SVH
`define DEVICE_DISCOVERY_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define DDT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddt assertion failed");
// Next-cycle implication, checked outside reset
`define DDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddt assertion failed");
`else
`define DDT_ASSERT_IMPL(label, ante, cons)
`define DDT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/ddt_pkg.sv
// ----------------------------------------------------------------------------
// Device discovery table package
// Types, codes and reset constants shared by the table logic.
// ----------------------------------------------------------------------------
package ddt_pkg;

  localparam int unsigned DEVICES_DEF = 16;

  localparam logic [15:0] FIND_INTERVAL_RST    = 16'd50;
  localparam logic [15:0] WAIT_TIMEOUT_RST     = 16'(2 * 100);
  localparam logic [15:0] INQUIRE_INTERVAL_RST = 16'd50;
  localparam logic [31:0] BCAST_ADDR           = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    STAT_IDLE   = 3'd0,
    STAT_HAS    = 3'd1,
    STAT_WAIT   = 3'd2,
    STAT_ACTIVE = 3'd3,
    STAT_INQ    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ACT_DISCOVER = 2'd0,
    ACT_INQUIRE  = 2'd1,
    ACT_ANNOUNCE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_FRAME   = 2'd1,
    REQ_POLL    = 2'd2,
    REQ_TIMEOUT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    FRM_DEVADDR = 2'd0,
    FRM_ACK     = 2'd1,
    FRM_OTHER   = 2'd2
  } frame_e;

  typedef enum logic [1:0] {
    CFG_FIND_INTERVAL    = 2'd0,
    CFG_WAIT_TIMEOUT     = 2'd1,
    CFG_INQUIRE_INTERVAL = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SC_ADD   = 2'd0,
    SC_ACK   = 2'd1,
    SC_DEACT = 2'd2,
    SC_POLL  = 2'd3
  } scan_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_POLL_D = 3'd2,
    S_POLL_I = 3'd3,
    S_FLUSH  = 3'd4
  } fsm_e;

  // One table entry as stored in the RAM; all-zero is the reset entry
  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
    logic [15:0] stamp;
  } entry_t;

  // Deadline check without wrap: stamp + interval <= now on 17 bits
  function automatic logic deadline_passed(logic [15:0] stamp, logic [15:0] intv,
                                           logic [15:0] now);
    logic [16:0] due;
    due = {1'b0, stamp} + {1'b0, intv};
    return due <= {1'b0, now};
  endfunction

endpackage

// File: rtl/ddt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ddt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/device_discovery_table_unit.sv
// ----------------------------------------------------------------------------
// Device discovery table unit
// Gateway table of managed device addresses with discovery and inquiry polls.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         request: type, kind, address, hop, tick
//  m_axis    out        message: action, target address, last of request
//  cfg       in         write-only interval registers
//
//  Entries live in one RAM read one entry per cycle. Add, acknowledge and
//  route timeout requests scan until the first hit or the last entry; a
//  poll runs one full scan then two write-back steps. A received frame
//  other than an acknowledge skips the scan. Reset clears per-entry valid
//  bits at once, so no clearing pass runs. A new request is taken while
//  messages of the previous one still wait on m_axis; it finishes once they
//  have drained.
`include "device_discovery_table_unit_macros.svh"

module device_discovery_table_unit #(
  parameter int unsigned DEVICES = ddt_pkg::DEVICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // addr[31:0], hop[39:32], now[55:40]
  input  logic [3:0]  s_axis_tuser,  // req_type[1:0], frame_kind[3:2]
  // message stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // target_addr[31:0]
  output logic [1:0]  m_axis_tuser,  // action[1:0]
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  import ddt_pkg::*;

  localparam int unsigned AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned CW = $clog2(DEVICES + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef struct packed {
    logic          found;
    logic [AW-1:0] idx;
    logic [31:0]   addr;
    logic [15:0]   stamp;
  } cand_t;

  fsm_e           state_q, state_d;
  scan_e          scan_q, scan_d;
  logic [31:0]    addr_q, addr_d;
  logic [15:0]    now_q, now_d;
  logic [CW-1:0]  rd_cnt_q, rd_cnt_d;
  logic           chk_vld_q, chk_vld_d;
  logic           chk_last_q, chk_last_d;
  logic [AW-1:0]  chk_idx_q, chk_idx_d;
  logic           rvld_q, rvld_d;
  logic [DEVICES-1:0] vld_q, vld_d;
  cand_t          has_q, has_d, wait_q, wait_d, act_q, act_d;
  logic [15:0]    disc_stamp_q, disc_stamp_d;
  logic [15:0]    find_q, find_d, wait_to_q, wait_to_d, inq_q, inq_d;
  action_e        res_act_q [2];
  action_e        res_act_d [2];
  logic [31:0]    res_tgt_q [2];
  logic [31:0]    res_tgt_d [2];
  logic [1:0]     res_cnt_q, res_cnt_d;
  action_e        out_act_q [2];
  action_e        out_act_d [2];
  logic [31:0]    out_tgt_q [2];
  logic [31:0]    out_tgt_d [2];
  logic [1:0]     out_cnt_q, out_cnt_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;

  entry_t         cur;
  logic           addr_nz, addr_eq;
  logic           early_hit, scan_done;
  logic           in_acc, out_acc;
  logic           disc_go, inq_go;
  logic           flush_go;
  cand_t          disc_c;

  // Entry RAM
  ddt_ram #(
    .WIDTH (EW),
    .DEPTH (DEVICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = out_tgt_q[0];
  assign m_axis_tuser  = out_act_q[0];
  assign m_axis_tlast  = (out_cnt_q == 2'd1);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // Hand over pending messages once the output buffer is empty
  assign flush_go = (state_q == S_FLUSH) && (res_cnt_q != 2'd0) && (out_cnt_q == 2'd0);

  // Read data, masked to the reset entry where never written
  assign cur     = rvld_q ? entry_t'(ram_rdata) : entry_t'('0);
  assign addr_nz = (cur.addr != 32'd0);
  assign addr_eq = (cur.addr == addr_q);

  // First-hit test for the scans that stop early
  always_comb begin
    case (scan_q)
      SC_ADD:   early_hit = (cur.status == STAT_IDLE);
      SC_ACK:   early_hit = addr_nz && (cur.status != STAT_ACTIVE) && addr_eq;
      SC_DEACT: early_hit = addr_nz && (cur.status == STAT_ACTIVE) && addr_eq;
      default:  early_hit = 1'b0;
    endcase
  end

  assign scan_done = chk_vld_q && (early_hit || chk_last_q);

  // Poll decisions on the candidates from the scan
  assign disc_c  = has_q.found ? has_q : wait_q;
  assign disc_go = has_q.found ? deadline_passed(disc_stamp_q, find_q, now_q)
                               : (wait_q.found &&
                                  deadline_passed(wait_q.stamp, wait_to_q, now_q));
  assign inq_go  = act_q.found && deadline_passed(act_q.stamp, inq_q, now_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((s_axis_tuser[1:0] == REQ_FRAME) && (s_axis_tuser[3:2] != FRM_ACK)) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = (scan_q == SC_POLL) ? S_POLL_D : S_FLUSH;
        end
      end
      S_POLL_D: state_d = S_POLL_I;
      S_POLL_I: state_d = S_FLUSH;
      S_FLUSH: begin
        if ((res_cnt_q == 2'd0) || (out_cnt_q == 2'd0)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM access and message buffers
  always_comb begin
    scan_d       = scan_q;
    addr_d       = addr_q;
    now_d        = now_q;
    rd_cnt_d     = rd_cnt_q;
    chk_vld_d    = 1'b0;
    chk_last_d   = chk_last_q;
    chk_idx_d    = chk_idx_q;
    vld_d        = vld_q;
    has_d        = has_q;
    wait_d       = wait_q;
    act_d        = act_q;
    disc_stamp_d = disc_stamp_q;
    find_d       = find_q;
    wait_to_d    = wait_to_q;
    inq_d        = inq_q;
    res_act_d    = res_act_q;
    res_tgt_d    = res_tgt_q;
    res_cnt_d    = res_cnt_q;
    out_act_d    = out_act_q;
    out_tgt_d    = out_tgt_q;
    out_cnt_d    = out_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = cur;
    ram_raddr    = rd_cnt_q[AW-1:0];
    rvld_d       = vld_q[ram_raddr];

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FIND_INTERVAL:    find_d    = cfg_wdata_i;
        CFG_WAIT_TIMEOUT:     wait_to_d = cfg_wdata_i;
        CFG_INQUIRE_INTERVAL: inq_d     = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      // Take a request and pick its scan
      S_IDLE: begin
        if (in_acc) begin
          addr_d      = s_axis_tdata[31:0];
          now_d       = s_axis_tdata[55:40];
          rd_cnt_d    = '0;
          res_cnt_d   = 2'd0;
          has_d.found  = 1'b0;
          wait_d.found = 1'b0;
          act_d.found  = 1'b0;
          case (req_e'(s_axis_tuser[1:0]))
            REQ_ADD:     scan_d = SC_ADD;
            REQ_FRAME:   scan_d = SC_ACK;
            REQ_POLL:    scan_d = SC_POLL;
            REQ_TIMEOUT: scan_d = SC_DEACT;
            default:     scan_d = SC_ADD;
          endcase
          if ((s_axis_tuser[1:0] == REQ_FRAME) && (s_axis_tuser[3:2] == FRM_DEVADDR)) begin
            res_cnt_d = 2'd1;
            if (s_axis_tdata[39:32] == 8'd0) begin
              res_act_d[0] = ACT_ANNOUNCE;
              res_tgt_d[0] = BCAST_ADDR;
            end else begin
              res_act_d[0] = ACT_DISCOVER;
              res_tgt_d[0] = s_axis_tdata[31:0];
            end
          end
        end
      end

      // Issue one read per cycle, check the entry read the cycle before
      S_SCAN: begin
        if (rd_cnt_q < CW'(DEVICES)) begin
          chk_vld_d  = 1'b1;
          chk_last_d = (rd_cnt_q == CW'(DEVICES - 1));
          chk_idx_d  = rd_cnt_q[AW-1:0];
          rd_cnt_d   = rd_cnt_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (scan_q == SC_POLL) begin
            if (!has_q.found && addr_nz && (cur.status == STAT_HAS)) begin
              has_d = '{found: 1'b1, idx: chk_idx_q, addr: cur.addr, stamp: cur.stamp};
            end
            if (!wait_q.found && addr_nz && (cur.status == STAT_WAIT)) begin
              wait_d = '{found: 1'b1, idx: chk_idx_q, addr: cur.addr, stamp: cur.stamp};
            end
            if (!act_q.found && addr_nz && (cur.status == STAT_ACTIVE)) begin
              act_d = '{found: 1'b1, idx: chk_idx_q, addr: cur.addr, stamp: cur.stamp};
            end
          end else if (early_hit) begin
            ram_we = 1'b1;
            vld_d[chk_idx_q] = 1'b1;
            case (scan_q)
              SC_ADD: begin
                ram_wdata.addr   = addr_q;
                ram_wdata.status = STAT_HAS;
              end
              SC_ACK: begin
                ram_wdata.status = STAT_ACTIVE;
                ram_wdata.stamp  = now_q;
              end
              default: ram_wdata.status = STAT_IDLE;
            endcase
          end
        end
      end

      // Discovery to a new device, or resend to a waiting one
      S_POLL_D: begin
        if (disc_go) begin
          ram_we       = 1'b1;
          ram_waddr    = disc_c.idx;
          ram_wdata    = '{addr: disc_c.addr, status: STAT_WAIT, stamp: now_q};
          vld_d[disc_c.idx] = 1'b1;
          res_act_d[0] = ACT_DISCOVER;
          res_tgt_d[0] = disc_c.addr;
          res_cnt_d    = 2'd1;
          if (has_q.found) begin
            disc_stamp_d = now_q;
          end
        end
      end

      // Inquiry to the first active device
      S_POLL_I: begin
        if (inq_go) begin
          ram_we    = 1'b1;
          ram_waddr = act_q.idx;
          ram_wdata = '{addr: act_q.addr, status: STAT_INQ, stamp: now_q};
          vld_d[act_q.idx] = 1'b1;
          res_act_d[res_cnt_q[0]] = ACT_INQUIRE;
          res_tgt_d[res_cnt_q[0]] = act_q.addr;
          res_cnt_d = res_cnt_q + 2'd1;
        end
      end

      // Hand messages to the output buffer once it is empty
      S_FLUSH: begin
        if (flush_go) begin
          out_act_d = res_act_q;
          out_tgt_d = res_tgt_q;
          out_cnt_d = res_cnt_q;
          res_cnt_d = 2'd0;
        end
      end

      default: ;
    endcase

    // Advance the output buffer on each taken message
    if (out_acc) begin
      out_act_d[0] = out_act_q[1];
      out_tgt_d[0] = out_tgt_q[1];
      out_cnt_d    = out_cnt_q - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= SC_ADD;
      rd_cnt_q     <= '0;
      chk_vld_q    <= 1'b0;
      rvld_q       <= 1'b0;
      vld_q        <= '0;
      has_q        <= '0;
      wait_q       <= '0;
      act_q        <= '0;
      disc_stamp_q <= 16'd0;
      find_q       <= FIND_INTERVAL_RST;
      wait_to_q    <= WAIT_TIMEOUT_RST;
      inq_q        <= INQUIRE_INTERVAL_RST;
      res_cnt_q    <= 2'd0;
      out_cnt_q    <= 2'd0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      rd_cnt_q     <= rd_cnt_d;
      chk_vld_q    <= chk_vld_d;
      rvld_q       <= rvld_d;
      vld_q        <= vld_d;
      has_q        <= has_d;
      wait_q       <= wait_d;
      act_q        <= act_d;
      disc_stamp_q <= disc_stamp_d;
      find_q       <= find_d;
      wait_to_q    <= wait_to_d;
      inq_q        <= inq_d;
      res_cnt_q    <= res_cnt_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    now_q      <= now_d;
    chk_last_q <= chk_last_d;
    chk_idx_q  <= chk_idx_d;
    res_act_q  <= res_act_d;
    res_tgt_q  <= res_tgt_d;
    out_act_q  <= out_act_d;
    out_tgt_q  <= out_tgt_d;
  end

  // Assertions
  `DDT_ASSERT_IMPL(a_write_state, ram_we, (state_q != S_IDLE) && (state_q != S_FLUSH))
  `DDT_ASSERT_NEXT(a_write_sets_valid, ram_we, vld_q[$past(ram_waddr)])
  `DDT_ASSERT_NEXT(a_flush_copy, flush_go, out_cnt_q == $past(res_cnt_q))
  `DDT_ASSERT_IMPL(a_read_bound, state_q == S_SCAN, rd_cnt_q <= CW'(DEVICES))

endmodule
